@@ src/ow_pkg.sv @@
package ow_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_RELEASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_RESET = 2'd1,
    FN_WRITE = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LOW     = 2'd1,
    PH_SAMPLE  = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [9:0] presence_wait_ticks;
    logic [9:0] reset_tail_ticks;
    logic [7:0] one_low_ticks;
    logic [7:0] one_release_ticks;
    logic [7:0] zero_low_ticks;
    logic [7:0] read_low_ticks;
    logic [7:0] read_tail_ticks;
  } ow_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_seen;
    logic [7:0] read_value;
  } ow_res_t;

endpackage

@@ src/ow_core.sv @@
module ow_core #(
  parameter int BITS_PER_BYTE = 8,
  parameter int TIMER_WIDTH   = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [1:0]       func,
  input  logic [7:0]       data_byte,
  input  logic             line_level,
  input  ow_pkg::ow_cfg_t  cfg,
  output ow_pkg::ow_res_t  res
);
  import ow_pkg::*;

  localparam int TW = TIMER_WIDTH;
  localparam int PW = $clog2(BITS_PER_BYTE + 1);

  phase_t        phase_r, phase_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    shift_r, shift_nxt;
  func_t         cmd_r, cmd_nxt;
  logic          presence_r, presence_nxt;
  logic [7:0]    received_r, received_nxt;

  logic [PW-1:0] pos_inc;
  logic          bit_cur;
  logic          bit_inc;
  logic          do_rel;
  logic          do_end;
  logic [TW-1:0] rel_len;
  logic [6:0]    pos_wide;

  function automatic logic [TW-1:0] min_one(logic [TW-1:0] v);
    return (v == '0) ? TW'(1) : v;
  endfunction

  // Bits past the eighth of a byte read as zero.
  function automatic logic bit_of(logic [7:0] sh, logic [PW-1:0] p);
    logic [6:0] pw;
    pw = 7'(p);
    return (pw < 7'd8) ? sh[pw[2:0]] : 1'b0;
  endfunction

  function automatic logic [TW-1:0] low_len(func_t c, logic b, ow_cfg_t k);
    logic [TW-1:0] len;
    case (c)
      FN_RESET: len = TW'(k.reset_low_ticks);
      FN_WRITE: len = b ? TW'(k.one_low_ticks) : TW'(k.zero_low_ticks);
      default:  len = TW'(k.read_low_ticks);
    endcase
    return min_one(len);
  endfunction

  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    pos_nxt      = pos_r;
    shift_nxt    = shift_r;
    cmd_nxt      = cmd_r;
    presence_nxt = presence_r;
    received_nxt = received_r;
    do_rel       = 1'b0;
    do_end       = 1'b0;
    rel_len      = '0;
    pos_inc      = pos_r + PW'(1);
    bit_cur      = bit_of(shift_r, pos_r);
    bit_inc      = bit_of(shift_r, pos_inc);
    pos_wide     = 7'(pos_r);

    if (func_t'(func) == FN_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (timer_r > TW'(1)) begin
          timer_nxt = timer_r - TW'(1);
        end else begin
          unique case (phase_r)
            PH_IDLE: begin
            end
            PH_LOW: begin
              if (cmd_r == FN_WRITE) begin
                // A zero bit gets one release tick of recovery.
                rel_len = bit_cur ? TW'(cfg.one_release_ticks) : TW'(1);
                do_rel  = 1'b1;
              end else begin
                phase_nxt = PH_SAMPLE;
                timer_nxt = (cmd_r == FN_RESET) ? min_one(TW'(cfg.presence_wait_ticks))
                                                : TW'(1);
              end
            end
            PH_SAMPLE: begin
              if (cmd_r == FN_RESET) begin
                presence_nxt = !line_level;
                rel_len      = TW'(cfg.reset_tail_ticks);
              end else begin
                if (pos_wide < 7'd8 && line_level) begin
                  shift_nxt[pos_wide[2:0]] = 1'b1;
                end
                rel_len = TW'(cfg.read_tail_ticks);
              end
              do_rel = 1'b1;
            end
            PH_RELEASE: begin
              do_end = 1'b1;
            end
          endcase
        end
      end

      if (do_rel) begin
        if (rel_len == '0) begin
          do_end = 1'b1;
        end else begin
          phase_nxt = PH_RELEASE;
          timer_nxt = rel_len;
        end
      end

      if (do_end) begin
        if (cmd_r != FN_RESET && 32'(pos_inc) < BITS_PER_BYTE) begin
          pos_nxt   = pos_inc;
          phase_nxt = PH_LOW;
          timer_nxt = low_len(cmd_r, bit_inc, cfg);
          do_end    = 1'b0;
        end else begin
          if (cmd_r != FN_RESET) begin
            pos_nxt = pos_inc;
          end
          if (cmd_r == FN_READ) begin
            received_nxt = shift_nxt;
          end
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end
      end
    end else if (phase_r == PH_IDLE) begin
      cmd_nxt   = func_t'(func);
      pos_nxt   = '0;
      shift_nxt = (func_t'(func) == FN_WRITE) ? data_byte : 8'h00;
      phase_nxt = PH_LOW;
      timer_nxt = low_len(func_t'(func), data_byte[0], cfg);
    end

    res.drive_low     = (phase_nxt == PH_LOW);
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = do_end;
    res.presence_seen = presence_nxt;
    res.read_value    = received_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      timer_r    <= '0;
      pos_r      <= '0;
      shift_r    <= '0;
      cmd_r      <= FN_TICK;
      presence_r <= 1'b0;
      received_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      pos_r      <= pos_nxt;
      shift_r    <= shift_nxt;
      cmd_r      <= cmd_nxt;
      presence_r <= presence_nxt;
      received_r <= received_nxt;
    end
  end

endmodule

@@ src/one_wire_bus_master.sv @@
// 1-Wire bus master, paced by requests on the input channel.
// Each input request is either a tick (one microsecond of bus time, with the
// line level sampled during it) or a command: reset with presence detect,
// write a byte, or read a byte, least significant bit first. A command that
// arrives while another is in progress is ignored.
// Every input request produces exactly one result request. The result tells
// whether to pull the bus low during the next tick, whether a command is in
// progress, whether it finished on this request, the last presence sample
// and the last byte read.
// The result is registered: it sits in the output register in the cycle
// after the input is accepted. Throughput is one request per cycle while the
// receiver keeps up, set by the sequencer update feeding the output register.
// If the receiver stalls, the output register holds its result and in_ready
// drops only while that result is still waiting; it rises again in the
// cycle the result is taken, so back-to-back flow continues.
// Slot widths are set through the configuration port, which is always ready
// and should be written only while the block is idle. Synchronous reset
// restores the default slot widths, clears the sequencer to idle and
// empties the output register.
module one_wire_bus_master #(
  parameter int BITS_PER_BYTE = 8,
  parameter int TIMER_WIDTH   = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_line_level,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_drive_low,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_presence_seen,
  output logic [7:0]                    out_read_value,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ow_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ow_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ow_pkg::*;

  ow_cfg_t cfg_r;
  ow_res_t res;
  ow_res_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    in_accept;

  // The output register frees up when it is empty or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Register file for the slot widths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= 10'd480;
      cfg_r.presence_wait_ticks <= 10'd80;
      cfg_r.reset_tail_ticks    <= 10'd400;
      cfg_r.one_low_ticks       <= 8'd1;
      cfg_r.one_release_ticks   <= 8'd50;
      cfg_r.zero_low_ticks      <= 8'd50;
      cfg_r.read_low_ticks      <= 8'd2;
      cfg_r.read_tail_ticks     <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESET_LOW:     cfg_r.reset_low_ticks     <= cfg_data;
        REG_PRESENCE_WAIT: cfg_r.presence_wait_ticks <= cfg_data;
        REG_RESET_TAIL:    cfg_r.reset_tail_ticks    <= cfg_data;
        REG_ONE_LOW:       cfg_r.one_low_ticks       <= cfg_data[7:0];
        REG_ONE_RELEASE:   cfg_r.one_release_ticks   <= cfg_data[7:0];
        REG_ZERO_LOW:      cfg_r.zero_low_ticks      <= cfg_data[7:0];
        REG_READ_LOW:      cfg_r.read_low_ticks      <= cfg_data[7:0];
        REG_READ_TAIL:     cfg_r.read_tail_ticks     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer advances its state only on an accepted request, and its
  // combinational result lands in the output register on the same edge.
  ow_core #(
    .BITS_PER_BYTE (BITS_PER_BYTE),
    .TIMER_WIDTH   (TIMER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_accept),
    .func       (in_func),
    .data_byte  (in_data_byte),
    .line_level (in_line_level),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_low     = res_r.drive_low;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;
  assign out_presence_seen = res_r.presence_seen;
  assign out_read_value    = res_r.read_value;

endmodule
